/* rtl/radial_cut_mean_covariance_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the radial cut mean/covariance core
// Shared property wrappers on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef RADIAL_CUT_MEAN_COVARIANCE_CORE_DEFINES_SVH
`define RADIAL_CUT_MEAN_COVARIANCE_CORE_DEFINES_SVH

// same-cycle implication
`define RCMC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcmc assertion failed");

// next-cycle implication
`define RCMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcmc assertion failed");

`endif

/* rtl/rcmc_pkg.sv */
// ----------------------------------------------------------------------------
// rcmc_pkg
// Types, constants and helpers of the radial cut mean/covariance core.
// ----------------------------------------------------------------------------
package rcmc_pkg;

  localparam int COORD_W    = 24;
  localparam int COORD_BITS = 24;
  localparam int MAX_POINTS = 65536;
  localparam int CNT_W      = 17;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int NRES       = 20;

  localparam logic signed [64:0] SAT_HI = 65'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [64:0] SAT_LO = -65'sh0_8000_0000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t [3:0] c;
    logic         pass;
    logic         last;
  } q_entry_t;

  typedef enum logic [1:0] {F_IDLE, F_SQ, F_PUSH} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_ACC, B_EMIT, B_DIV, B_MA, B_MB, B_SUB, B_OUT
  } back_state_t;

  function automatic logic signed [47:0] sat48(input logic signed [64:0] v);
    if (v > SAT_HI) return 48'sh7FFF_FFFF_FFFF;
    else if (v < SAT_LO) return 48'sh8000_0000_0000;
    else return v[47:0];
  endfunction

endpackage

/* rtl/rcmc_front.sv */
// ----------------------------------------------------------------------------
// rcmc_front
// Accepts a point, forms x^2+y^2+z^2 on one multiplier, classifies the
// point against the radial cut and pushes it into the point queue.
// ----------------------------------------------------------------------------
module rcmc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  rcmc_pkg::coord_t         coord_t,
  input  rcmc_pkg::coord_t         coord_x,
  input  rcmc_pkg::coord_t         coord_y,
  input  rcmc_pkg::coord_t         coord_z,
  input  logic                     last_point,
  input  logic [47:0]              rmax_squared,
  output logic                     q_push,
  input  logic                     q_full,
  output rcmc_pkg::q_entry_t       q_data
);
  import rcmc_pkg::*;

  // the coord_t port hides the package type of the same name here
  front_state_t state, state_next;
  logic [1:0]                  step;
  rcmc_pkg::coord_t [3:0]      c;
  logic                        last;
  logic signed [47:0]          prod;
  logic [47:0]                 r2;
  rcmc_pkg::coord_t            sq_op;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    full       = (state != F_IDLE);
    q_push     = 1'b0;
    unique case (state)
      F_IDLE: if (push) state_next = F_SQ;
      F_SQ:   if (step == 2'd3) state_next = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // pick the component to square
  always_comb begin
    case (step)
      2'd0:    sq_op = c[1];
      2'd1:    sq_op = c[2];
      default: sq_op = c[3];
    endcase
  end

  // capture the point and accumulate the squares
  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      c[0] <= COORD_W'(signed'(coord_t[COORD_BITS-1:0]));
      c[1] <= COORD_W'(signed'(coord_x[COORD_BITS-1:0]));
      c[2] <= COORD_W'(signed'(coord_y[COORD_BITS-1:0]));
      c[3] <= COORD_W'(signed'(coord_z[COORD_BITS-1:0]));
      last <= last_point;
      step <= 2'd0;
    end else if (state == F_SQ) begin
      step <= step + 2'd1;
      prod <= sq_op * sq_op;
      if (step == 2'd1) r2 <= prod;
      else if (step != 2'd0) r2 <= r2 + prod;
    end
  end

  assign q_data.c    = c;
  assign q_data.pass = (r2 < rmax_squared);
  assign q_data.last = last;

endmodule

/* rtl/rcmc_queue.sv */
// ----------------------------------------------------------------------------
// rcmc_queue
// Short point queue between the classifier and the accumulator.
// ----------------------------------------------------------------------------
module rcmc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rcmc_pkg::q_entry_t  wdata,
  input  logic                pop,
  output logic                empty,
  output rcmc_pkg::q_entry_t  rdata
);
  import rcmc_pkg::*;

  q_entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0]   wptr, rptr;
  logic [QPTR_W:0]     cnt;
  logic                do_push, do_pop;

  assign full    = (cnt == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

  // store a beat
  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

endmodule

/* rtl/rcmc_div.sv */
// ----------------------------------------------------------------------------
// rcmc_div
// Restoring divider, one quotient bit per cycle: signed 64-bit dividend by
// unsigned count, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module rcmc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [63:0]          dividend,
  input  logic [rcmc_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic signed [64:0]          quotient
);
  import rcmc_pkg::*;

  logic [63:0]      mag;
  logic [CNT_W-1:0] rem, dvs;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic [6:0]       left;
  logic             neg, busy;

  assign trial = {rem, mag[63]};
  assign diff  = trial - {1'b0, dvs};

  // iterate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= 7'd64;
        neg  <= dividend[63];
        mag  <= dividend[63] ? 64'(-dividend) : 64'(dividend);
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (!diff[CNT_W]) begin
          rem <= diff[CNT_W-1:0];
          mag <= {mag[62:0], 1'b1};
        end else begin
          rem <= trial[CNT_W-1:0];
          mag <= {mag[62:0], 1'b0};
        end
        left <= left - 7'd1;
        if (left == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

/* rtl/rcmc_back.sv */
// ----------------------------------------------------------------------------
// rcmc_back
// Pops classified points, accumulates count, sums and product sums on one
// shared multiplier, and on the last point emits means and covariances.
// ----------------------------------------------------------------------------
module rcmc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  rcmc_pkg::q_entry_t          q_data,
  output logic                        empty,
  input  logic                        pop,
  output logic                        kind,
  output logic [1:0]                  row,
  output logic [1:0]                  col,
  output logic signed [47:0]          value,
  output logic [rcmc_pkg::CNT_W-1:0]  point_total,
  output logic                        empty_res,
  output logic                        last_result
);
  import rcmc_pkg::*;
  `include "radial_cut_mean_covariance_core_defines.svh"

  back_state_t state, state_next;

  logic [CNT_W-1:0]    count;
  logic signed [40:0]  csum [4];
  logic signed [63:0]  psum [16];
  coord_t [3:0]        ra, rb;
  coord_t              mean [4];
  logic                pt_last;
  logic [4:0]          i;
  logic [3:0]          pidx, rd;
  logic                pv;
  logic signed [47:0]  prod;
  logic [4:0]          k;
  logic [3:0]          j;
  logic [1:0]          ma_sel;
  coord_t              ma;
  logic signed [47:0]  mm, mp, val;
  logic                o_valid, load, take, set_empty;
  logic                div_start, div_done;
  logic signed [63:0]  dividend;
  logic signed [64:0]  quot;

  assign take      = !q_empty && state == B_IDLE;
  assign set_empty = (count == '0);
  assign j         = 4'(k - 5'd4);
  assign rd        = (state == B_ACC) ? pidx : j;
  assign ma_sel    = (state == B_MB) ? j[1:0] : j[3:2];
  assign dividend  = (k < 5'd4) ? {{23{csum[k[1:0]][40]}}, csum[k[1:0]]} : psum[rd];

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    load       = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.pass && count < CNT_W'(MAX_POINTS)) state_next = B_ACC;
          else if (q_data.last) state_next = B_EMIT;
        end
      end
      B_ACC:  if (i == 5'd16) state_next = pt_last ? B_EMIT : B_IDLE;
      B_EMIT: begin
        if (set_empty) state_next = B_OUT;
        else begin
          div_start  = 1'b1;
          state_next = B_DIV;
        end
      end
      B_DIV:  if (div_done) state_next = (k < 5'd4) ? B_OUT : B_MA;
      B_MA:   state_next = B_MB;
      B_MB:   state_next = B_SUB;
      B_SUB:  state_next = B_OUT;
      B_OUT: begin
        if (!o_valid || pop) begin
          load       = 1'b1;
          state_next = (k == 5'(NRES-1)) ? B_IDLE : B_EMIT;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // accumulate state; clear after the last result
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int n = 0; n < 4; n++) csum[n] <= '0;
      for (int n = 0; n < 16; n++) psum[n] <= '0;
    end else if (load && k == 5'(NRES-1)) begin
      count <= '0;
      for (int n = 0; n < 4; n++) csum[n] <= '0;
      for (int n = 0; n < 16; n++) psum[n] <= '0;
    end else begin
      if (take && q_data.pass && count < CNT_W'(MAX_POINTS)) begin
        count <= count + 1'b1;
        for (int n = 0; n < 4; n++) csum[n] <= csum[n] + 41'(q_data.c[n]);
      end
      if (state == B_ACC && pv) psum[pidx] <= psum[rd] + {{16{prod[47]}}, prod};
    end
  end

  // product sweep over rotating operand lines
  always_ff @(posedge clk) begin
    if (take) begin
      ra      <= q_data.c;
      rb      <= q_data.c;
      pt_last <= q_data.last;
      i       <= '0;
      pv      <= 1'b0;
      k       <= '0;
    end else if (state == B_ACC) begin
      i  <= i + 5'd1;
      pv <= (i < 5'd16);
      if (i < 5'd16) begin
        prod <= ra[0] * rb[0];
        pidx <= i[3:0];
      end
      rb <= {rb[0], rb[3:1]};
      if (i[1:0] == 2'd3) ra <= {ra[0], ra[3:1]};
    end else begin
      if (state == B_EMIT && set_empty) val <= '0;
      if (state == B_DIV && div_done) begin
        if (k < 5'd4) begin
          mean[k[1:0]] <= quot[COORD_W-1:0];
          val          <= sat48(quot);
        end else mp <= sat48(quot);
      end
      if (state == B_MA) ma <= mean[ma_sel];
      if (state == B_MB) mm <= ma * mean[ma_sel];
      if (state == B_SUB) val <= sat48({{17{mp[47]}}, mp} - {{17{mm[47]}}, mm});
      if (load) k <= k + 5'd1;
    end
  end

  // hold the result beat until popped
  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (load) o_valid <= 1'b1;
    else if (pop) o_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind        <= (k >= 5'd4);
      row         <= (k < 5'd4) ? k[1:0] : j[3:2];
      col         <= (k < 5'd4) ? 2'd0 : j[1:0];
      value       <= val;
      point_total <= count;
      empty_res   <= set_empty;
      last_result <= (k == 5'(NRES-1));
    end
  end

  assign empty = !o_valid;

  rcmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (quot)
  );

  `RCMC_ASSERT_IMPL(a_last_is_cov33, !empty && last_result, kind && row == 2'd3 && col == 2'd3)
  `RCMC_ASSERT_IMPL(a_empty_zero, !empty && empty_res, value == '0 && point_total == '0)
  `RCMC_ASSERT_IMPL(a_count_cap, 1'b1, count <= CNT_W'(MAX_POINTS))
  `RCMC_ASSERT_NEXT(a_final_clears, load && k == 5'(NRES-1), count == '0)

endmodule

/* rtl/radial_cut_mean_covariance_core.sv */
// ----------------------------------------------------------------------------
// radial_cut_mean_covariance_core
// Streaming 4D mean and covariance of points inside a radial cut.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive coord_t..coord_z and last_point with push; a beat
//   is taken when push is high and full is low. Result queue: while empty
//   is low the oldest result sits on kind/row/col/value/point_total/
//   empty_res/last_result; pop takes it.
//   Configuration: cfg_data written to rmax_squared on cfg_valid (cfg_ready
//   is always high); write only while the block is idle.
//   Points: the classifier takes a new point only once it has squared
//   and pushed the last one (three squares on one multiplier). The
//   accumulator forms sixteen products on one shared multiplier for a
//   point inside the cut and only pops a rejected one; a four-entry
//   queue parts the two. Results: a last point yields 20 results, four
//   means then sixteen covariance entries. Each mean of a non-empty set
//   waits on the bit-serial divider; a covariance entry also passes
//   B_MA, B_MB and B_SUB for the mean product. An empty set skips both.
//   Stall: a held result blocks only the emission sequence; points keep
//   entering until the queue fills; full then stays high.
//   Reset: rmax_squared returns to all ones, count and sums clear, both
//   queues empty.
// ----------------------------------------------------------------------------
module radial_cut_mean_covariance_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  rcmc_pkg::coord_t            coord_t,
  input  rcmc_pkg::coord_t            coord_x,
  input  rcmc_pkg::coord_t            coord_y,
  input  rcmc_pkg::coord_t            coord_z,
  input  logic                        last_point,
  output logic                        empty,
  input  logic                        pop,
  output logic                        kind,
  output logic [1:0]                  row,
  output logic [1:0]                  col,
  output logic signed [47:0]          value,
  output logic [rcmc_pkg::CNT_W-1:0]  point_total,
  output logic                        empty_res,
  output logic                        last_result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [47:0]                 cfg_data
);
  import rcmc_pkg::*;

  logic [47:0] rmax_squared;
  logic        fq_push, fq_full, bq_pop, bq_empty;
  q_entry_t    fq_data, bq_data;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) rmax_squared <= '1;
    else if (cfg_valid && cfg_ready) rmax_squared <= cfg_data;
  end

  rcmc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .coord_t      (coord_t),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .last_point   (last_point),
    .rmax_squared (rmax_squared),
    .q_push       (fq_push),
    .q_full       (fq_full),
    .q_data       (fq_data)
  );

  rcmc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .full  (fq_full),
    .wdata (fq_data),
    .pop   (bq_pop),
    .empty (bq_empty),
    .rdata (bq_data)
  );

  rcmc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (bq_empty),
    .q_pop       (bq_pop),
    .q_data      (bq_data),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .row         (row),
    .col         (col),
    .value       (value),
    .point_total (point_total),
    .empty_res   (empty_res),
    .last_result (last_result)
  );

endmodule
